// ===== src/isl_pkg.sv =====
// Shared types and codes for the indexed shift list.
// Used by isl_cell and indexed_shift_list_core; depends on nothing else.
package isl_pkg;

    // Wide enough for a position or length at the largest supported depth (1024).
    localparam int POS_W = 11;

    localparam logic [2:0] OP_SET    = 3'd0;
    localparam logic [2:0] OP_GET    = 3'd1;
    localparam logic [2:0] OP_INSERT = 3'd2;
    localparam logic [2:0] OP_APPEND = 3'd3;
    localparam logic [2:0] OP_DELETE = 3'd4;
    localparam logic [2:0] OP_INIT   = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]  operation;
        logic [4:0]  index;
        logic [63:0] value;
    } t_in_item;

    typedef struct packed {
        logic [63:0] read_value;
        logic [1:0]  status;
        logic [4:0]  length;
    } t_out_item;

    typedef enum logic [2:0] {
        CM_HOLD   = 3'd0,
        CM_WRITE  = 3'd1,
        CM_INSERT = 3'd2,
        CM_DELETE = 3'd3,
        CM_ZERO   = 3'd4
    } t_cell_mode;

    // Broadcast to every cell; each cell decides its own move from its position.
    typedef struct packed {
        t_cell_mode       mode;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] cnt;
        logic [63:0]      value;
    } t_cell_cmd;

endpackage

// ===== src/isl_cell.sv =====
// One storage cell of the shift list: holds a word, loads it from the
// broadcast value, from a neighbor, or zero. Depends on isl_pkg.
module isl_cell #(
    parameter int unsigned POS = 0
) (
    input  logic               i_clk,
    input  isl_pkg::t_cell_cmd i_cmd,
    input  logic [63:0]        i_left,
    input  logic [63:0]        i_right,
    output logic [63:0]        o_data
);
    import isl_pkg::*;

    localparam logic [POS_W-1:0] KP = POS_W'(POS);

    logic [63:0] r_data;
    logic [63:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_cmd.mode)
            CM_WRITE: begin
                if (KP == i_cmd.pos) n_data = i_cmd.value;
            end
            CM_INSERT: begin
                if (KP == i_cmd.pos) begin
                    n_data = i_cmd.value;
                end else if (KP > i_cmd.pos && KP <= i_cmd.cnt) begin
                    n_data = i_left;
                end
            end
            CM_DELETE: begin
                // the last live word stays; it falls off the end with the length
                if (KP >= i_cmd.pos && ({1'b0, KP} + 1'b1) < {1'b0, i_cmd.cnt}) begin
                    n_data = i_right;
                end
            end
            CM_ZERO: begin
                if (KP < i_cmd.pos) n_data = '0;
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== src/indexed_shift_list_core.sv =====
// Indexed shift list: a length-tracked row of DEPTH 64-bit cells.
// Depends on isl_pkg and isl_cell.
//
// Each transfer carries one operation (set, get, insert, append, delete, init) and
// yields exactly one result holding the word read, a status and the new length.
// In every operation all cells load from their left or right
// neighbor, the broadcast word or zero at the same clock edge, so a new item is
// accepted in every cycle while the result register is empty or being drained.
// The result is registered; input stalls only while a result waits untaken.
// Only the first 32 positions are reachable through the 5-bit index, and the
// reported length is the low 5 bits of the count. Stored words need no reset;
// the range checks keep every read inside the written part of the list.
module indexed_shift_list_core #(
    parameter int unsigned DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  isl_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output isl_pkg::t_out_item o_out_data
);
    import isl_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int RD_N = (DEPTH < 32) ? DEPTH : 32;
    localparam logic [POS_W-1:0] DEPTH_P = POS_W'(DEPTH);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    t_out_item     r_out;

    logic             w_accept;
    logic [POS_W-1:0] w_idx;
    logic [POS_W-1:0] w_cnt;
    logic [POS_W-1:0] w_cnt_next;
    logic [1:0]       w_status;
    logic             w_do_read;
    logic [63:0]      w_rd;
    t_cell_cmd        w_cmd;
    logic [63:0]      w_data [DEPTH];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_idx      = POS_W'(i_in_data.index);
    assign w_cnt      = POS_W'(r_count);

    always_comb begin
        w_status    = ST_OK;
        w_cnt_next  = w_cnt;
        w_do_read   = 1'b0;
        w_cmd.mode  = CM_HOLD;
        w_cmd.pos   = w_idx;
        w_cmd.cnt   = w_cnt;
        w_cmd.value = i_in_data.value;
        case (i_in_data.operation)
            OP_SET: begin
                if (w_idx < w_cnt) w_cmd.mode = CM_WRITE;
                else               w_status   = ST_RANGE;
            end
            OP_GET: begin
                if (w_idx < w_cnt) w_do_read = 1'b1;
                else               w_status  = ST_RANGE;
            end
            OP_INSERT: begin
                if (w_idx > w_cnt) begin
                    w_status = ST_RANGE;
                end else if (w_cnt >= DEPTH_P) begin
                    w_status = ST_FULL;
                end else begin
                    w_cmd.mode = CM_INSERT;
                    w_cnt_next = w_cnt + 1'b1;
                end
            end
            OP_APPEND: begin
                if (w_cnt >= DEPTH_P) begin
                    w_status = ST_FULL;
                end else begin
                    // insert at the end moves nothing
                    w_cmd.mode = CM_INSERT;
                    w_cmd.pos  = w_cnt;
                    w_cnt_next = w_cnt + 1'b1;
                end
            end
            OP_DELETE: begin
                if (w_idx < w_cnt) begin
                    w_cmd.mode = CM_DELETE;
                    w_cnt_next = w_cnt - 1'b1;
                end else begin
                    w_status = ST_RANGE;
                end
            end
            OP_INIT: begin
                if (w_idx > DEPTH_P) begin
                    w_status = ST_RANGE;
                end else begin
                    w_cmd.mode = CM_ZERO;
                    w_cnt_next = w_idx;
                end
            end
            default: w_status = ST_OK;
        endcase
        if (!w_accept) w_cmd.mode = CM_HOLD;
    end

    assign n_count = w_accept ? CW'(w_cnt_next) : r_count;

    always_comb begin
        w_rd = '0;
        for (int k = 0; k < RD_N; k++) begin
            if (w_do_read && i_in_data.index == 5'(k)) w_rd = w_data[k];
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [63:0] w_left;
        logic [63:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end
        isl_cell #(.POS(g)) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept)         r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out.read_value <= w_rd;
            r_out.status     <= w_status;
            r_out.length     <= w_cnt_next[4:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        POS_W'(r_count) <= DEPTH_P)
        else $error("list length beyond depth");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_out_valid)
        else $error("accepted item produced no result");

    a_full_only_at_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_status == ST_FULL) |-> (w_cnt == DEPTH_P))
        else $error("full flagged below depth");

    a_fail_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_status != ST_OK) |=> (r_count == $past(r_count)))
        else $error("failed operation changed length");

    a_read_only_on_get: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.operation != OP_GET) |=> (r_out.read_value == '0))
        else $error("nonzero read value for non-get");

endmodule

// ===== sim/indexed_shift_list_core_tb.sv =====
// Self-checking testbench for indexed_shift_list_core: directed and random list traffic
// with random stalls on both sides. A local list predictor checks every result in order.
// Depends on isl_pkg and the RTL of indexed_shift_list_core.
module indexed_shift_list_core_tb;
    import isl_pkg::*;

    localparam int LIST_DEPTH   = 16;
    localparam int MAX_SHOWN    = 10;
    localparam int RANDOM_ITEMS = 1100;
    localparam int DRAIN_CYCLES = 4;

    // Operation codes with no function; the block answers them with ok and no change.
    localparam logic [2:0] OP_UNUSED_A = 3'd6;
    localparam logic [2:0] OP_UNUSED_B = 3'd7;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    logic [63:0] list_words [LIST_DEPTH];
    int unsigned list_len;
    t_out_item   expected_results[$];
    t_out_item   oldest_expected;
    int          mismatches;
    int          send_idle_pct;
    int          recv_idle_pct;

    indexed_shift_list_core #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Applies one operation to the local list copy and returns the result it should give.
    function automatic t_out_item list_apply(t_in_item item);
        t_out_item   res;
        int unsigned idx;
        int unsigned k;
        res = '0;
        res.status = ST_OK;
        idx = item.index;
        case (item.operation)
            OP_SET: begin
                if (idx < list_len) list_words[idx] = item.value;
                else res.status = ST_RANGE;
            end
            OP_GET: begin
                if (idx < list_len) res.read_value = list_words[idx];
                else res.status = ST_RANGE;
            end
            OP_INSERT: begin
                if (idx > list_len) begin
                    res.status = ST_RANGE;
                end else if (list_len >= LIST_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (k = list_len; k > idx; k--) list_words[k] = list_words[k-1];
                    list_words[idx] = item.value;
                    list_len++;
                end
            end
            OP_APPEND: begin
                if (list_len >= LIST_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    list_words[list_len] = item.value;
                    list_len++;
                end
            end
            OP_DELETE: begin
                if (idx < list_len) begin
                    for (k = idx + 1; k < list_len; k++) list_words[k-1] = list_words[k];
                    list_len--;
                end else begin
                    res.status = ST_RANGE;
                end
            end
            OP_INIT: begin
                if (idx > LIST_DEPTH) begin
                    res.status = ST_RANGE;
                end else begin
                    for (k = 0; k < idx; k++) list_words[k] = '0;
                    list_len = idx;
                end
            end
            default: ;
        endcase
        res.length = list_len[4:0];
        return res;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_op(input logic [2:0] op, input int unsigned idx,
                           input logic [63:0] value);
        t_in_item item;
        item.operation = op;
        item.index     = idx[4:0];
        item.value     = value;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        expected_results.push_back(list_apply(item));
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n) i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected result: read_value=%h status=%0d length=%0d",
                             o_out_data.read_value, o_out_data.status, o_out_data.length);
            end else begin
                oldest_expected = expected_results.pop_front();
                if (o_out_data.read_value !== oldest_expected.read_value ||
                    o_out_data.status !== oldest_expected.status ||
                    o_out_data.length !== oldest_expected.length) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("mismatch: expected %h/%0d/%0d, got %h/%0d/%0d",
                                 oldest_expected.read_value, oldest_expected.status,
                                 oldest_expected.length, o_out_data.read_value,
                                 o_out_data.status, o_out_data.length);
                end
            end
        end
    end

    task automatic test_empty_list();
        send_op(OP_GET, 0, 64'h0);
        send_op(OP_SET, 0, 64'hDEAD_BEEF_0000_0001);
        send_op(OP_DELETE, 0, 64'h0);
        send_op(OP_INSERT, 1, 64'h1);
    endtask

    task automatic test_insert_append();
        send_op(OP_APPEND, 0, '1);
        send_op(OP_APPEND, 0, '0);
        send_op(OP_INSERT, 0, 64'h0123_4567_89AB_CDEF);
        send_op(OP_INSERT, 3, 64'hFEDC_BA98_7654_3210);
        send_op(OP_INSERT, 1, 64'hAAAA_5555_AAAA_5555);
        send_op(OP_SET, 2, {$urandom, $urandom});
        send_op(OP_GET, 0, 64'h0);
        send_op(OP_GET, 4, 64'h0);
        send_op(OP_DELETE, 0, 64'h0);
        send_op(OP_DELETE, list_len - 1, 64'h0);
        send_op(OP_GET, 31, 64'h0);
    endtask

    task automatic test_full_list();
        send_op(OP_INIT, LIST_DEPTH, 64'h0);
        send_op(OP_APPEND, 0, 64'h5);
        // out of range wins over full
        send_op(OP_INSERT, LIST_DEPTH + 1, 64'h6);
        send_op(OP_INSERT, 5, 64'h7);
        send_op(OP_GET, LIST_DEPTH - 1, 64'h0);
        send_op(OP_DELETE, LIST_DEPTH - 1, 64'h0);
        send_op(OP_INIT, LIST_DEPTH + 1, 64'h0);
        send_op(OP_INIT, 31, 64'h0);
    endtask

    task automatic test_init_clear();
        send_op(OP_INIT, 0, 64'h0);
        send_op(OP_GET, 0, 64'h0);
    endtask

    task automatic test_unused_ops();
        send_op(OP_UNUSED_A, 3, '1);
        send_op(OP_UNUSED_B, 31, '1);
    endtask

    // Mostly in-range indexes so the list grows, fills and shrinks; some arbitrary ones.
    task automatic test_random_traffic(input int num_items);
        int          sent;
        int unsigned roll;
        int unsigned limit;
        int unsigned idx;
        logic [2:0]  op;
        logic [63:0] value;
        sent = 0;
        while (sent < num_items) begin
            roll = $urandom_range(99);
            if (roll < 16) op = OP_SET;
            else if (roll < 34) op = OP_GET;
            else if (roll < 50) op = OP_INSERT;
            else if (roll < 66) op = OP_APPEND;
            else if (roll < 82) op = OP_DELETE;
            else if (roll < 90) op = OP_INIT;
            else if (roll < 93) op = $urandom_range(1) ? OP_UNUSED_A : OP_UNUSED_B;
            else op = OP_APPEND;
            value = {$urandom, $urandom};
            if ($urandom_range(15) == 0) value = $urandom_range(1) ? '1 : '0;
            if (op == OP_INIT) begin
                roll = $urandom_range(7);
                if (roll < 2) idx = LIST_DEPTH;
                else if (roll == 2) idx = $urandom_range(31);
                else idx = $urandom_range(LIST_DEPTH);
            end else begin
                limit = (op == OP_INSERT) ? list_len + 1 : list_len;
                if (limit == 0 || $urandom_range(4) == 0) idx = $urandom_range(31);
                else idx = $urandom_range(limit - 1);
            end
            send_op(op, idx, value);
            if (op <= OP_INIT) sent++;
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_out_ready   = 1'b0;
        list_len      = 0;
        mismatches    = 0;
        send_idle_pct = 35;
        recv_idle_pct = 47;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_insert_append();
        test_full_list();
        test_init_clear();
        test_unused_ops();

        test_random_traffic(RANDOM_ITEMS / 3);
        send_idle_pct = 47;
        recv_idle_pct = 35;
        test_random_traffic(RANDOM_ITEMS / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        i_in_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("FAILURE");
        $finish;
    end

endmodule
